// File: hdl/plcl_pkg.sv
// Package with shared types and constants for the curve lookup block.
package plcl_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int NUM_COORDS = 5;
    localparam int DATA_W     = 32;
    localparam int COEF_W     = 16;
    localparam int QUO_CNT_W  = $clog2(COEF_W + 1);

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef word_t [NUM_COORDS-1:0] point_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APPEND,
        ST_RD_FIRST,
        ST_CHK_FIRST,
        ST_RD_LAST,
        ST_CHK_LAST,
        ST_RD_MID,
        ST_CHK_MID,
        ST_RD_LO,
        ST_RD_HI,
        ST_DIVIDE,
        ST_MULT,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              capture_in;
        logic              write_point;
        logic [ADDR_W-1:0] rd_addr;
        logic              set_lo_mid;
        logic              set_hi_mid;
        logic              load_a;
        logic              load_b;
        logic              copy_result;
        logic              clear_result;
        logic              div_start;
        logic              div_step;
        logic              mul_step;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic t_le_rd;
        logic t_ge_rd;
        logic t_lt_rd;
    } dp_sts_t;

endpackage

// File: hdl/piecewise_linear_curve_lookup.sv
// Top level of the piecewise linear curve lookup block.
// An append writes the captured point into the stores; a dropped append (store full) or a
// query on an empty store goes straight to the result. A query clamps to the first or the
// last point, or else searches (at most 10 steps), reads both bracketing points, divides
// and multiplies to interpolate. One word at a time: the next word is taken only after the
// result has been taken. Reset (rst_n, async low) empties the store; no clearing pass.
module piecewise_linear_curve_lookup (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic signed [31:0] sample_time,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  logic signed [31:0] coord_w,
    input  logic signed [31:0] coord_extra,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic signed [31:0] out_w,
    output logic signed [31:0] out_extra,
    output logic [1:0]         status
);
    import plcl_pkg::*;

    dp_cmd_t           cmd;
    dp_sts_t           sts;
    logic [CNT_W-1:0]  count;
    logic [ADDR_W-1:0] lo_idx, hi_idx;
    point_t            coords, result;

    assign coords = {coord_extra, coord_w, coord_z, coord_y, coord_x};
    assign out_x     = result[0];
    assign out_y     = result[1];
    assign out_z     = result[2];
    assign out_w     = result[3];
    assign out_extra = result[4];

    plcl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .count(count), .lo_idx(lo_idx), .hi_idx(hi_idx),
        .sts(sts), .cmd(cmd)
    );

    plcl_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .sample_time(sample_time), .coords(coords),
        .count(count), .lo_idx(lo_idx), .hi_idx(hi_idx), .result(result)
    );

endmodule

// File: hdl/plcl_ram.sv
// Generic single-port RAM with registered read.
module plcl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one entry per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: hdl/plcl_datapath.sv
// Datapath: point stores, search bounds, serial divider and serial multiplier.
module plcl_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  plcl_pkg::dp_cmd_t        cmd,
    output plcl_pkg::dp_sts_t        sts,
    input  plcl_pkg::word_t          sample_time,
    input  plcl_pkg::point_t         coords,
    input  logic [plcl_pkg::CNT_W-1:0] count,
    output logic [plcl_pkg::ADDR_W-1:0] lo_idx,
    output logic [plcl_pkg::ADDR_W-1:0] hi_idx,
    output plcl_pkg::point_t         result
);
    import plcl_pkg::*;

    word_t               t_reg;
    point_t              in_pt_reg;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   addr;
    word_t               rd_time;
    point_t              rd_pt;
    word_t               lo_time_reg;
    logic [ADDR_W-1:0]   lo_reg, lo_next, hi_reg, hi_next, mid;
    point_t              a_reg, b_reg;
    point_t              res_reg;
    logic [DATA_W:0]     rem_reg, rem_next, den_reg;
    logic [DATA_W+1:0]   rem_sh;
    logic [COEF_W-1:0]   quo_reg;
    logic signed [DATA_W:0]          diff;
    logic signed [DATA_W+COEF_W+1:0] prod;
    word_t                           sum;

    assign wr_addr = count[ADDR_W-1:0];
    assign addr    = cmd.write_point ? wr_addr : cmd.rd_addr;
    assign mid     = ADDR_W'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign lo_idx  = lo_reg;
    assign hi_idx  = hi_reg;
    assign result  = res_reg;

    // Capture the input word.
    always_ff @(posedge clk)
    begin
        if (cmd.capture_in)
        begin
            t_reg     <= sample_time;
            in_pt_reg <= coords;
        end
    end

    // Point stores.
    plcl_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_time_ram (
        .clk(clk), .we(cmd.write_point), .addr(addr), .wdata(t_reg), .rdata(rd_time)
    );
    for (genvar g = 0; g < NUM_COORDS; g++)
    begin : g_coord_ram
        plcl_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_ram (
            .clk(clk), .we(cmd.write_point), .addr(addr),
            .wdata(in_pt_reg[g]), .rdata(rd_pt[g])
        );
    end

    // Comparisons of the query time against the word just read.
    assign sts.t_le_rd = t_reg <= rd_time;
    assign sts.t_ge_rd = t_reg >= rd_time;
    assign sts.t_lt_rd = t_reg < rd_time;

    // Search bounds.
    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.capture_in)
        begin
            lo_next = '0;
            hi_next = ADDR_W'(count - CNT_W'(1));
        end
        else if (cmd.set_lo_mid)
        begin
            lo_next = mid;
        end
        else if (cmd.set_hi_mid)
        begin
            hi_next = mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg <= '0;
            hi_reg <= '0;
        end
        else
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    // Restoring divider, one quotient bit per cycle.
    assign rem_sh   = {rem_reg, 1'b0};
    always_comb
    begin
        rem_next = rem_sh[DATA_W:0];
        if (rem_sh >= {1'b0, den_reg})
        begin
            rem_next = (DATA_W+1)'(rem_sh - {1'b0, den_reg});
        end
    end

    // Serial multiply-add over the five coordinates.
    assign diff = {b_reg[0][DATA_W-1], b_reg[0]} - {a_reg[0][DATA_W-1], a_reg[0]};
    assign prod = diff * $signed({1'b0, quo_reg});
    assign sum  = DATA_W'(a_reg[0] + DATA_W'(prod >>> COEF_W));

    always_ff @(posedge clk)
    begin
        if (cmd.load_a)
        begin
            a_reg       <= rd_pt;
            lo_time_reg <= rd_time;
        end
        if (cmd.load_b)
        begin
            b_reg <= rd_pt;
        end
        // The divide starts while the upper bracketing point is on the read port.
        if (cmd.div_start)
        begin
            rem_reg <= (DATA_W+1)'({t_reg[DATA_W-1], t_reg}
                       - {lo_time_reg[DATA_W-1], lo_time_reg});
            den_reg <= (DATA_W+1)'({rd_time[DATA_W-1], rd_time}
                       - {lo_time_reg[DATA_W-1], lo_time_reg});
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[COEF_W-2:0], (rem_sh >= {1'b0, den_reg})};
        end
        if (cmd.clear_result)
        begin
            res_reg <= '0;
        end
        else if (cmd.copy_result)
        begin
            res_reg <= rd_pt;
        end
        else if (cmd.mul_step)
        begin
            res_reg <= {sum, res_reg[NUM_COORDS-1:1]};
            a_reg   <= {a_reg[0], a_reg[NUM_COORDS-1:1]};
            b_reg   <= {b_reg[0], b_reg[NUM_COORDS-1:1]};
        end
    end

endmodule

// File: hdl/plcl_ctrl.sv
// Controller state machine: sequences appends, search, divide and multiply.
module plcl_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [plcl_pkg::CNT_W-1:0]    count,
    input  logic [plcl_pkg::ADDR_W-1:0]   lo_idx,
    input  logic [plcl_pkg::ADDR_W-1:0]   hi_idx,
    input  plcl_pkg::dp_sts_t             sts,
    output plcl_pkg::dp_cmd_t             cmd
);
    import plcl_pkg::*;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [1:0]           status_reg, status_next;
    logic                 out_valid_reg, out_valid_next;
    logic [QUO_CNT_W-1:0] step_reg, step_next;
    logic [ADDR_W-1:0]    mid;
    logic                 accept;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign count     = count_reg;
    assign mid       = ADDR_W'(({1'b0, lo_idx} + {1'b0, hi_idx}) >> 1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!mode)
                        state_next = (count_reg == CNT_W'(MAX_POINTS)) ? ST_DONE : ST_APPEND;
                    else
                        state_next = (count_reg == '0) ? ST_DONE : ST_RD_FIRST;
                end
            end
            ST_APPEND:    state_next = ST_DONE;
            ST_RD_FIRST:  state_next = ST_CHK_FIRST;
            ST_CHK_FIRST: state_next = sts.t_le_rd ? ST_DONE : ST_RD_LAST;
            ST_RD_LAST:   state_next = ST_CHK_LAST;
            ST_CHK_LAST:
            begin
                if (sts.t_ge_rd)
                    state_next = ST_DONE;
                else if (hi_idx - lo_idx > ADDR_W'(1))
                    state_next = ST_RD_MID;
                else
                    state_next = ST_RD_LO;
            end
            ST_RD_MID:    state_next = ST_CHK_MID;
            ST_CHK_MID:
            begin
                // Bounds update this cycle; test the updated gap.
                if (sts.t_lt_rd)
                    state_next = (mid - lo_idx > ADDR_W'(1)) ? ST_RD_MID : ST_RD_LO;
                else
                    state_next = (hi_idx - mid > ADDR_W'(1)) ? ST_RD_MID : ST_RD_LO;
            end
            ST_RD_LO:     state_next = ST_RD_HI;
            ST_RD_HI:     state_next = ST_DIVIDE;
            ST_DIVIDE:
                state_next = (step_reg == QUO_CNT_W'(COEF_W)) ? ST_MULT : ST_DIVIDE;
            ST_MULT:
                state_next = (step_reg == QUO_CNT_W'(NUM_COORDS - 1)) ? ST_DONE : ST_MULT;
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs and commands.
    always_comb
    begin
        cmd            = '0;
        count_next     = count_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;
        step_next      = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture_in   = accept;
                cmd.clear_result = accept;
                // The status of a waiting result holds until a new word arrives.
                if (accept)
                begin
                    status_next = STATUS_OK;
                    if (!mode && count_reg == CNT_W'(MAX_POINTS))
                        status_next = STATUS_FULL;
                    if (mode && count_reg == '0)
                        status_next = STATUS_EMPTY;
                end
            end
            ST_APPEND:
            begin
                cmd.write_point = 1'b1;
                count_next      = count_reg + CNT_W'(1);
            end
            ST_RD_FIRST:
            begin
                cmd.rd_addr = '0;
            end
            ST_CHK_FIRST:
            begin
                cmd.copy_result = sts.t_le_rd;
                cmd.rd_addr     = hi_idx;
            end
            ST_RD_LAST:
            begin
                cmd.rd_addr = hi_idx;
            end
            ST_CHK_LAST:
            begin
                cmd.copy_result = sts.t_ge_rd;
            end
            ST_RD_MID:
            begin
                cmd.rd_addr = mid;
            end
            ST_CHK_MID:
            begin
                cmd.set_hi_mid = sts.t_lt_rd;
                cmd.set_lo_mid = !sts.t_lt_rd;
            end
            ST_RD_LO:
            begin
                cmd.rd_addr = lo_idx;
            end
            ST_RD_HI:
            begin
                cmd.rd_addr   = hi_idx;
                cmd.load_a    = 1'b1;
                step_next     = '0;
            end
            ST_DIVIDE:
            begin
                if (step_reg == '0)
                begin
                    cmd.load_b    = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.rd_addr   = hi_idx;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
                if (step_reg == QUO_CNT_W'(COEF_W))
                    step_next = '0;
                else
                    step_next = step_reg + QUO_CNT_W'(1);
            end
            ST_MULT:
            begin
                cmd.mul_step = 1'b1;
                step_next    = step_reg + QUO_CNT_W'(1);
            end
            ST_DONE:
            begin
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            status_reg    <= STATUS_OK;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

endmodule

// File: hdl/plcl_checker.sv
// Port-level checker for the curve lookup block, bound to the top level.
module plcl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status
);

    // A result stays offered until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Status codes are never the unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("bad status code");

    // No new word is taken while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken with result pending");

    // An accepted word produces no result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result too early");

endmodule

bind piecewise_linear_curve_lookup plcl_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status)
);
